[hdl/escape_sequence_boundary_tracker_defines.svh]
// Assertion macros for the escape sequence boundary tracker.
`ifndef ESCAPE_SEQUENCE_BOUNDARY_TRACKER_DEFINES_SVH
`define ESCAPE_SEQUENCE_BOUNDARY_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define ESBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ESBT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ESBT_ASSERT(label, prop, msg)
`define ESBT_ASSERT_RST(label, prop, msg)
`endif
`endif

[hdl/esbt_pkg.sv]
// Shared constants, types and sequence tables for the boundary tracker.
package esbt_pkg;

    localparam int OUT_W              = 48;
    localparam int POSITION_WIDTH_DEF = 48;

    localparam logic [7:0] ESC_BYTE       = 8'h1b;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5c;

    // last index of each matched sequence
    localparam logic [1:0] OPEN_LAST = 2'd2;
    localparam logic [2:0] SYNC_LAST = 3'd7;

    typedef struct packed {
        logic [OUT_W-1:0] position;
        logic             inside_graphics;
        logic             graphics_closed_here;
        logic             sync_closed_here;
        logic             render_boundary;
        logic [OUT_W-1:0] last_graphics_end;
        logic [OUT_W-1:0] latest_sync_end;
    } t_result;

    // ESC _ G
    function automatic logic [7:0] open_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = ESC_BYTE;
            2'd1:    v = 8'h5f;
            2'd2:    v = 8'h47;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // ESC [ ? 2 0 2 6 l
    function automatic logic [7:0] sync_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = ESC_BYTE;
            3'd1:    v = 8'h5b;
            3'd2:    v = 8'h3f;
            3'd3:    v = 8'h32;
            3'd4:    v = 8'h30;
            3'd5:    v = 8'h32;
            3'd6:    v = 8'h36;
            3'd7:    v = 8'h6c;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[hdl/esbt_scan.sv]
// Byte counter, sequence matchers and end-position state.
module esbt_scan #(
    parameter int POSITION_WIDTH = esbt_pkg::POSITION_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    output esbt_pkg::t_result o_res
);
    import esbt_pkg::*;

    logic [POSITION_WIDTH-1:0] r_bytes, n_bytes;
    logic [POSITION_WIDTH-1:0] r_gend, n_gend;
    logic [POSITION_WIDTH-1:0] r_send, n_send;
    logic [1:0]                r_gm, n_gm;
    logic [2:0]                r_sm, n_sm;
    logic                      r_in_gfx, n_in_gfx;
    logic                      r_esc, n_esc;
    logic                      w_gclosed, w_sclosed, w_is_esc;

    always_comb begin
        w_is_esc  = (i_byte == ESC_BYTE);
        n_bytes   = (&r_bytes) ? r_bytes : r_bytes + 1'b1;
        n_gend    = r_gend;
        n_send    = r_send;
        n_gm      = r_gm;
        n_sm      = r_sm;
        n_in_gfx  = r_in_gfx;
        n_esc     = r_esc;
        w_gclosed = 1'b0;
        w_sclosed = 1'b0;

        if (r_in_gfx) begin
            if (r_esc && i_byte == BACKSLASH_BYTE) begin
                n_in_gfx  = 1'b0;
                n_esc     = 1'b0;
                n_gend    = n_bytes;
                w_gclosed = 1'b1;
            end else begin
                n_esc = w_is_esc;
            end
        end else if (r_gm <= OPEN_LAST && i_byte == open_byte(r_gm)) begin
            if (r_gm == OPEN_LAST) begin
                n_in_gfx = 1'b1;
                n_esc    = 1'b0;
                n_gm     = 2'd0;
            end else begin
                n_gm = r_gm + 2'd1;
            end
        end else begin
            n_gm = {1'b0, w_is_esc};
        end

        if (i_byte == sync_byte(r_sm)) begin
            if (r_sm == SYNC_LAST) begin
                n_send    = n_bytes;
                n_sm      = 3'd0;
                w_sclosed = 1'b1;
            end else begin
                n_sm = r_sm + 3'd1;
            end
        end else begin
            n_sm = {2'b00, w_is_esc};
        end

        o_res.position             = OUT_W'(n_bytes);
        o_res.inside_graphics      = n_in_gfx;
        o_res.graphics_closed_here = w_gclosed;
        o_res.sync_closed_here     = w_sclosed;
        o_res.render_boundary      = (n_gend != '0) && (n_send > n_gend);
        o_res.last_graphics_end    = OUT_W'(n_gend);
        o_res.latest_sync_end      = OUT_W'(n_send);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes  <= '0;
            r_gend   <= '0;
            r_send   <= '0;
            r_gm     <= '0;
            r_sm     <= '0;
            r_in_gfx <= 1'b0;
            r_esc    <= 1'b0;
        end else if (i_en) begin
            r_bytes  <= n_bytes;
            r_gend   <= n_gend;
            r_send   <= n_send;
            r_gm     <= n_gm;
            r_sm     <= n_sm;
            r_in_gfx <= n_in_gfx;
            r_esc    <= n_esc;
        end
    end

endmodule

[hdl/escape_sequence_boundary_tracker.sv]
// Top level of the escape sequence boundary tracker: input and result registers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  input   | in        | i_valid / o_stall  | i_stream_byte
//  result  | out       | o_valid / i_stall  | o_position ... o_latest_sync_end
//
// One beat per cycle unless the result stalls; an accepted byte moves on to the
// result register, the scan state updating as it leaves the input register.
// Reset clears the counter, matchers and end positions at once; no clearing pass.
// A stalled result holds while the input register still takes one more byte;
// o_stall rises only when both registers are full and the result is stalled.
module escape_sequence_boundary_tracker #(
    parameter int POSITION_WIDTH = esbt_pkg::POSITION_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_stream_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [esbt_pkg::OUT_W-1:0] o_position,
    output logic                       o_inside_graphics,
    output logic                       o_graphics_closed_here,
    output logic                       o_sync_closed_here,
    output logic                       o_render_boundary,
    output logic [esbt_pkg::OUT_W-1:0] o_last_graphics_end,
    output logic [esbt_pkg::OUT_W-1:0] o_latest_sync_end
);
    import esbt_pkg::*;

    `include "escape_sequence_boundary_tracker_defines.svh"

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_res, w_res;
    logic       w_adv, w_take;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign w_take  = i_valid && !o_stall;

    esbt_scan #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_byte (r_in_byte),
        .o_res  (w_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_stream_byte;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_position             = r_res.position;
    assign o_inside_graphics      = r_res.inside_graphics;
    assign o_graphics_closed_here = r_res.graphics_closed_here;
    assign o_sync_closed_here     = r_res.sync_closed_here;
    assign o_render_boundary      = r_res.render_boundary;
    assign o_last_graphics_end    = r_res.last_graphics_end;
    assign o_latest_sync_end      = r_res.latest_sync_end;

    `ESBT_ASSERT(a_in_hold, r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_byte), "input beat lost while waiting")
    `ESBT_ASSERT(a_gfx_close, o_valid && o_graphics_closed_here |-> o_last_graphics_end == o_position && !o_inside_graphics, "graphics close not recorded at this position")
    `ESBT_ASSERT(a_sync_close, o_valid && o_sync_closed_here |-> o_latest_sync_end == o_position, "sync end not recorded at this position")
    `ESBT_ASSERT_RST(a_reset_idle, !$past(i_rst_n) |-> !o_valid && !o_stall, "handshake not idle after reset")

endmodule

[tb/tb_escape_sequence_boundary_tracker.sv]
// Testbench for the escape sequence boundary tracker: byte streams checked beat by beat.
module tb_escape_sequence_boundary_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import esbt_pkg::*;

    // narrow counter, widened to the 48-bit outputs
    localparam int POS_W          = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1590;
    localparam int MAX_REPORTS    = 10;

    localparam logic [0:2][7:0] OPEN_SEQ = {ESC_BYTE, 8'h5f, 8'h47};
    localparam logic [0:7][7:0] SYNC_SEQ = {ESC_BYTE, 8'h5b, 8'h3f, 8'h32,
                                            8'h30, 8'h32, 8'h36, 8'h6c};
    localparam int OPEN_LEN = 3;
    localparam int SYNC_LEN = 8;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic [7:0]       i_stream_byte = 8'h00;
    logic             i_stall       = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [OUT_W-1:0] o_position;
    logic             o_inside_graphics;
    logic             o_graphics_closed_here;
    logic             o_sync_closed_here;
    logic             o_render_boundary;
    logic [OUT_W-1:0] o_last_graphics_end;
    logic [OUT_W-1:0] o_latest_sync_end;

    escape_sequence_boundary_tracker #(
        .POSITION_WIDTH(POS_W)
    ) u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_stream_byte         (i_stream_byte),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_position            (o_position),
        .o_inside_graphics     (o_inside_graphics),
        .o_graphics_closed_here(o_graphics_closed_here),
        .o_sync_closed_here    (o_sync_closed_here),
        .o_render_boundary     (o_render_boundary),
        .o_last_graphics_end   (o_last_graphics_end),
        .o_latest_sync_end     (o_latest_sync_end)
    );

    always #5 i_clk = ~i_clk;

    // scan state of the predictor
    logic [POS_W-1:0] seen_cnt     = '0;
    logic [POS_W-1:0] gfx_end_pos  = '0;
    logic [POS_W-1:0] sync_end_pos = '0;
    int unsigned      open_idx     = 0;
    int unsigned      sync_idx     = 0;
    logic             in_gfx       = 1'b0;
    logic             esc_seen     = 1'b0;

    t_result scan_results_q[$];
    int      mismatches   = 0;
    int      bytes_sent   = 0;
    int      idle_cycles  = 0;
    bit      tx_gaps_on   = 1'b1;
    bit      rx_stalls_on = 1'b1;
    bit      hold_req     = 1'b0;

    function automatic t_result track_byte(input logic [7:0] b);
        t_result r;
        logic    gclosed;
        logic    sclosed;
        gclosed = 1'b0;
        sclosed = 1'b0;
        if (seen_cnt != '1) seen_cnt = seen_cnt + 1'b1;

        if (in_gfx) begin
            if (esc_seen && b == BACKSLASH_BYTE) begin
                in_gfx      = 1'b0;
                esc_seen    = 1'b0;
                gfx_end_pos = seen_cnt;
                gclosed     = 1'b1;
            end else begin
                esc_seen = (b == ESC_BYTE);
            end
        end else if (b == OPEN_SEQ[open_idx]) begin
            open_idx++;
            if (open_idx == OPEN_LEN) begin
                in_gfx   = 1'b1;
                esc_seen = 1'b0;
                open_idx = 0;
            end
        end else begin
            open_idx = (b == ESC_BYTE) ? 1 : 0;
        end

        if (b == SYNC_SEQ[sync_idx]) begin
            sync_idx++;
            if (sync_idx == SYNC_LEN) begin
                sync_end_pos = seen_cnt;
                sync_idx     = 0;
                sclosed      = 1'b1;
            end
        end else begin
            sync_idx = (b == ESC_BYTE) ? 1 : 0;
        end

        r.position             = OUT_W'(seen_cnt);
        r.inside_graphics      = in_gfx;
        r.graphics_closed_here = gclosed;
        r.sync_closed_here     = sclosed;
        r.render_boundary      = (gfx_end_pos != '0) && (sync_end_pos > gfx_end_pos);
        r.last_graphics_end    = OUT_W'(gfx_end_pos);
        r.latest_sync_end      = OUT_W'(sync_end_pos);
        return r;
    endfunction

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scan_results_q.push_back(track_byte(b));
        bytes_sent++;
    endtask

    task automatic stop_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_open(input int n);
        for (int i = 0; i < n; i++) send_byte(OPEN_SEQ[i]);
    endtask

    task automatic send_sync(input int n);
        for (int i = 0; i < n; i++) send_byte(SYNC_SEQ[i]);
    endtask

    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return ESC_BYTE;
        if (r < 22) return BACKSLASH_BYTE;
        if (r < 27) return OPEN_SEQ[$urandom_range(1, 2)];
        if (r < 32) return SYNC_SEQ[$urandom_range(1, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_isolated_bytes();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(BACKSLASH_BYTE);
        // ESC backslash outside a graphics escape closes nothing
        send_byte(ESC_BYTE);
        send_byte(BACKSLASH_BYTE);
        stop_input();
    endtask

    task automatic test_graphics_escape();
        send_open(OPEN_LEN);
        send_byte(8'h78);
        // doubled ESC keeps the close armed
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(BACKSLASH_BYTE);
        stop_input();
    endtask

    task automatic test_sync_after_graphics();
        send_sync(SYNC_LEN);
        stop_input();
    endtask

    task automatic test_matcher_restart();
        // ESC on mismatch restarts the opener at one
        send_byte(ESC_BYTE);
        send_open(OPEN_LEN);
        send_byte(ESC_BYTE);
        send_byte(BACKSLASH_BYTE);
        stop_input();
    endtask

    task automatic test_random_stream();
        int start;
        int kind;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                tx_gaps_on   = $urandom_range(0, 2) != 0;
                rx_stalls_on = $urandom_range(0, 2) != 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_open(OPEN_LEN);
                len = $urandom_range(0, 10);
                repeat (len) send_byte(payload_byte());
                if ($urandom_range(0, 4) != 0) begin
                    send_byte(ESC_BYTE);
                    send_byte(BACKSLASH_BYTE);
                end
            end else if (kind < 55) begin
                send_sync(SYNC_LEN);
            end else if (kind < 70) begin
                if ($urandom_range(0, 1) != 0) send_open($urandom_range(1, OPEN_LEN - 1));
                else send_sync($urandom_range(1, SYNC_LEN - 1));
                send_byte(payload_byte());
            end else if (kind < 80) begin
                send_byte(ESC_BYTE);
                send_byte(payload_byte());
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) send_byte(8'($urandom_range(0, 255)));
            end
        end
        stop_input();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        send_open(OPEN_LEN);
        repeat (12) send_byte(payload_byte());
        send_byte(ESC_BYTE);
        send_byte(BACKSLASH_BYTE);
        send_sync(SYNC_LEN);
        repeat (10) send_byte(8'($urandom_range(0, 255)));
        stop_input();
        tx_gaps_on = 1'b1;
    endtask

    // result side
    initial begin : rx_proc
        int  rx_run;
        int  held;
        bit  rx_stalled;
        rx_run     = 0;
        held       = 0;
        rx_stalled = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held     = 0;
                end
            end else if (!rx_stalls_on) begin
                i_stall <= 1'b0;
            end else begin
                if (rx_run == 0) begin
                    rx_stalled = !rx_stalled;
                    rx_run     = rx_stalled ? pick_gap() : $urandom_range(1, 30);
                end
                if (rx_run == 0) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall <= rx_stalled;
                    rx_run--;
                end
            end
        end
    end

    task automatic flag_error(input string what, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    endtask

    task automatic check_field(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) flag_error(what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (scan_results_q.size() == 0) begin
                flag_error("unexpected beat, position", '0, o_position);
            end else begin
                want = scan_results_q.pop_front();
                check_field("position", want.position, o_position);
                check_field("inside_graphics", OUT_W'(want.inside_graphics),
                            OUT_W'(o_inside_graphics));
                check_field("graphics_closed_here", OUT_W'(want.graphics_closed_here),
                            OUT_W'(o_graphics_closed_here));
                check_field("sync_closed_here", OUT_W'(want.sync_closed_here),
                            OUT_W'(o_sync_closed_here));
                check_field("render_boundary", OUT_W'(want.render_boundary),
                            OUT_W'(o_render_boundary));
                check_field("last_graphics_end", want.last_graphics_end, o_last_graphics_end);
                check_field("latest_sync_end", want.latest_sync_end, o_latest_sync_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_isolated_bytes();
        test_graphics_escape();
        test_sync_after_graphics();
        test_matcher_restart();
        test_random_stream();
        test_backpressure();

        while (scan_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && scan_results_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
